// ===== hw/rtl/countdown_timer_bank_core_macros.svh =====
// ----------------------------------------------------------------------------
// countdown timer bank assertion macros
// shared property wrappers for the timer bank checks
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define CTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("countdown timer bank check failed");

// next-cycle implication under synchronous reset
`define CTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("countdown timer bank check failed");

`endif

// ===== hw/rtl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// countdown timer bank package
// sizes, codes and shared types of the timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 32;
    localparam int MILLIS_W    = 31;
    localparam int WHOLE_W     = 8;
    localparam int FRAC_W      = 32;
    localparam int SYS_MS_W    = 63;
    localparam int KIND_W      = 3;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARM     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ARM_DONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE_DONE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY_REPLY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE    = 3'd4;

    localparam logic CFG_TICK_WHOLE_MS = 1'b0;
    localparam logic CFG_TICK_FRACTION = 1'b1;

    localparam logic [WHOLE_W-1:0] TICK_WHOLE_MS_RST = 8'd54;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic             we;
        t_idx             waddr;
        logic [CNT_W-1:0] wdata;
        logic             re;
        t_idx             raddr;
    } t_mem_req;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        t_idx                timer_index;
        logic                ok;
        logic [CNT_W-1:0]    remaining;
        logic [SYS_MS_W-1:0] system_ms;
        logic                last;
    } t_result;

endpackage

// ===== hw/rtl/ctb_store.sv =====
// ----------------------------------------------------------------------------
// countdown timer bank count store
// synchronous count memory with written bits, one write and one read port
// ----------------------------------------------------------------------------
module ctb_store import ctb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_req         i_req,
    output logic [CNT_W-1:0] o_rdata
);

    logic [CNT_W-1:0]       r_mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_written;
    logic [CNT_W-1:0]       r_rdata;
    logic                   r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_written[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_written <= r_written[i_req.raddr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rdata = r_rd_written ? r_rdata : '0;

endmodule

// ===== hw/rtl/ctb_clock.sv =====
// ----------------------------------------------------------------------------
// countdown timer bank system clock
// tick period registers and the 63.32 millisecond clock accumulator
// ----------------------------------------------------------------------------
module ctb_clock import ctb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [FRAC_W-1:0]   i_cfg_wdata,
    input  logic                i_tick,
    output logic [WHOLE_W-1:0]  o_tick_whole_ms,
    output logic [SYS_MS_W-1:0] o_system_ms
);

    logic [WHOLE_W-1:0]  r_tick_whole;
    logic [FRAC_W-1:0]   r_tick_frac;
    logic [FRAC_W-1:0]   r_clk_frac;
    logic [SYS_MS_W-1:0] r_clk_ms;
    logic [FRAC_W:0]     frac_sum;

    assign frac_sum = {1'b0, r_clk_frac} + {1'b0, r_tick_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_whole <= TICK_WHOLE_MS_RST;
            r_tick_frac  <= '0;
            r_clk_frac   <= '0;
            r_clk_ms     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TICK_WHOLE_MS: r_tick_whole <= i_cfg_wdata[WHOLE_W-1:0];
                    CFG_TICK_FRACTION: r_tick_frac  <= i_cfg_wdata;
                    default:           r_tick_frac  <= r_tick_frac;
                endcase
            end
            if (i_tick) begin
                r_clk_frac <= frac_sum[FRAC_W-1:0];
                // fraction carry adds one ms, wraps modulo 2^63
                r_clk_ms   <= r_clk_ms + SYS_MS_W'(r_tick_whole)
                              + SYS_MS_W'(frac_sum[FRAC_W]);
            end
        end
    end

    assign o_tick_whole_ms = r_tick_whole;
    assign o_system_ms     = r_clk_ms;

endmodule

// ===== hw/rtl/ctb_seq.sv =====
// ----------------------------------------------------------------------------
// countdown timer bank sequencer
// request decode, free map, notify flags, tick sweep and result register
// ----------------------------------------------------------------------------
module ctb_seq import ctb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_in_mode,
    input  t_idx                i_in_handle,
    input  logic                i_in_alloc,
    input  logic [MILLIS_W-1:0] i_in_millis,
    input  logic                i_in_notify,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output t_result             o_out,
    output t_mem_req            o_mem_req,
    input  logic [CNT_W-1:0]    i_mem_rdata,
    output logic                o_tick,
    input  logic [WHOLE_W-1:0]  i_tick_whole_ms,
    input  logic [SYS_MS_W-1:0] i_system_ms
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_QRESP = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [MODE_W-1:0]      r_mode, n_mode;
    t_idx                   r_handle, n_handle;
    logic                   r_alloc, n_alloc;
    logic [MILLIS_W-1:0]    r_millis, n_millis;
    logic                   r_notify, n_notify;
    logic [TIMER_COUNT-1:0] r_map, n_map;
    logic [TIMER_COUNT-1:0] r_flag, n_flag;
    logic [IDX_W:0]         r_idx, n_idx;
    logic                   r_pend, n_pend;
    t_idx                   r_pidx, n_pidx;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   slot_free;
    logic                   out_load;
    t_result                res;
    t_idx                   free_idx;
    logic                   free_ok;
    t_idx                   arm_idx;
    logic                   arm_good;
    logic [CNT_W:0]         sub;
    logic [CNT_W-1:0]       sat;
    logic                   used;
    logic                   notice;
    logic                   stall;

    // lowest clear bit of the free map
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
            if (!r_map[i]) begin
                free_idx = t_idx'(i);
                free_ok  = 1'b1;
            end
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;
    assign arm_idx   = r_alloc ? free_idx : r_handle;
    assign arm_good  = r_alloc ? free_ok : 1'b1;

    // saturating subtract of the whole-ms period
    assign sub    = {i_mem_rdata[CNT_W-1], i_mem_rdata} - (CNT_W+1)'(i_tick_whole_ms);
    assign sat    = (sub[CNT_W] != sub[CNT_W-1]) ? {1'b1, {(CNT_W-1){1'b0}}}
                                                 : sub[CNT_W-1:0];
    assign used   = r_map[r_pidx];
    assign notice = r_pend && used && r_flag[r_pidx] && sat[CNT_W-1];
    assign stall  = notice && !slot_free;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_handle   = r_handle;
        n_alloc    = r_alloc;
        n_millis   = r_millis;
        n_notify   = r_notify;
        n_map      = r_map;
        n_flag     = r_flag;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        o_in_ready = 1'b0;
        o_tick     = 1'b0;
        o_mem_req  = '0;
        out_load   = 1'b0;
        res        = '0;
        res.system_ms = i_system_ms;
        res.last      = 1'b1;
        res.ok        = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode   = i_in_mode;
                    n_handle = i_in_handle;
                    n_alloc  = i_in_alloc;
                    n_millis = i_in_millis;
                    n_notify = i_in_notify;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_mode)
                    MODE_TICK: begin
                        o_tick  = 1'b1;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = ST_TICK;
                    end
                    MODE_ARM: begin
                        if (slot_free) begin
                            out_load = 1'b1;
                            res.kind = KIND_ARM_DONE;
                            res.ok   = arm_good;
                            if (arm_good) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = arm_idx;
                                o_mem_req.wdata = {1'b0, r_millis};
                                // a given handle keeps its allocated bit
                                if (r_alloc) begin
                                    n_map[arm_idx] = 1'b1;
                                end
                                n_flag[arm_idx] = r_notify;
                                res.timer_index = arm_idx;
                                res.remaining   = {1'b0, r_millis};
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    MODE_RELEASE: begin
                        if (slot_free) begin
                            out_load         = 1'b1;
                            res.kind         = KIND_RELEASE_DONE;
                            res.timer_index  = r_handle;
                            n_map[r_handle]  = 1'b0;
                            n_flag[r_handle] = 1'b0;
                            n_state          = ST_IDLE;
                        end
                    end
                    MODE_QUERY: begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = r_handle;
                        n_state         = ST_QRESP;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_QRESP: begin
                if (slot_free) begin
                    out_load        = 1'b1;
                    res.kind        = KIND_QUERY_REPLY;
                    res.timer_index = r_handle;
                    res.ok          = r_map[r_handle];
                    res.remaining   = i_mem_rdata;
                    n_state         = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (!stall) begin
                    // write back timer r_pidx while reading the next one
                    if (r_pend && used) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_pidx;
                        o_mem_req.wdata = sat;
                    end
                    if (notice) begin
                        out_load        = 1'b1;
                        res.kind        = KIND_EXPIRED;
                        res.timer_index = r_pidx;
                        res.remaining   = sat;
                        res.last        = 1'b0;
                    end
                    if (r_idx < (IDX_W+1)'(TIMER_COUNT)) begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = r_idx[IDX_W-1:0];
                        n_pend          = 1'b1;
                        n_pidx          = r_idx[IDX_W-1:0];
                        n_idx           = r_idx + (IDX_W+1)'(1);
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    res.kind = KIND_TICK_DONE;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_handle <= n_handle;
        r_alloc  <= n_alloc;
        r_millis <= n_millis;
        r_notify <= n_notify;
        r_pidx   <= n_pidx;
        if (out_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map       <= '0;
            r_flag      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_map   <= n_map;
            r_flag  <= n_flag;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/countdown_timer_bank_core.sv =====
// ----------------------------------------------------------------------------
// countdown timer bank core
// bank of sixteen countdown timers with free map and 63.32 ms system clock
// ----------------------------------------------------------------------------
// One request is handled at a time. Arm and release load their result in
// the execute state; a query reads the count memory there and loads its
// result in the response state. A tick sweeps the count memory once,
// reading one timer and writing back the previous one every cycle while no
// notice waits on a busy result port; the closing result also waits for
// the port. Results sit in an output register, so a taken result never
// blocks the next request.
`include "countdown_timer_bank_core_macros.svh"

module countdown_timer_bank_core import ctb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_wdata,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,   // handle, allocate_new, millis, notify
    input  logic [1:0]    s_axis_tuser,   // mode
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // timer_index, ok, remaining, system_ms
    output logic [2:0]    m_axis_tuser,   // kind
    output logic          m_axis_tlast
);

    t_mem_req            mem_req;
    logic [CNT_W-1:0]    mem_rdata;
    logic                tick;
    logic [WHOLE_W-1:0]  tick_whole_ms;
    logic [SYS_MS_W-1:0] system_ms;
    t_result             out;

    ctb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ctb_clock u_clock (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_tick          (tick),
        .o_tick_whole_ms (tick_whole_ms),
        .o_system_ms     (system_ms)
    );

    ctb_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_in_mode       (s_axis_tuser),
        .i_in_handle     (s_axis_tdata[3:0]),
        .i_in_alloc      (s_axis_tdata[4]),
        .i_in_millis     (s_axis_tdata[35:5]),
        .i_in_notify     (s_axis_tdata[36]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out           (out),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata),
        .o_tick          (tick),
        .i_tick_whole_ms (tick_whole_ms),
        .i_system_ms     (system_ms)
    );

    assign m_axis_tdata = {4'b0000, out.system_ms, out.remaining, out.ok, out.timer_index};
    assign m_axis_tuser = out.kind;
    assign m_axis_tlast = out.last;

    // only expired notices leave a run open
    `CTB_ASSERT_SAME(a_last_kind, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser != KIND_EXPIRED))
    // a notice always reports a negative count
    `CTB_ASSERT_SAME(a_notice_neg, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == KIND_EXPIRED, m_axis_tdata[36])
    // one request in flight at a time
    `CTB_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
